[rtl/tbts_pkg.sv]
// Shared types, codes and constants for the TFTP boot transfer sequencer.
// Used by every module under rtl; depends on nothing.
package tbts_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int RES_SLOTS       = 3;

    localparam logic [11:0] CHUNK_RST   = 12'd512;
    localparam logic [15:0] VER_RST     = 16'd0;
    localparam logic [7:0]  MODE_RST    = 8'd1;
    localparam logic [9:0]  ACKTO_RST   = 10'd500;
    localparam logic [7:0]  RBDELAY_RST = 8'd100;

    localparam logic [2:0] CFG_CHUNK   = 3'd0;
    localparam logic [2:0] CFG_VERSION = 3'd1;
    localparam logic [2:0] CFG_MODE    = 3'd2;
    localparam logic [2:0] CFG_ACKTO   = 3'd3;
    localparam logic [2:0] CFG_RBDELAY = 3'd4;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_POLL   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [15:0] PT_RRQ  = 16'd1;
    localparam logic [15:0] PT_WRQ  = 16'd2;
    localparam logic [15:0] PT_DATA = 16'd3;
    localparam logic [15:0] PT_ACK  = 16'd4;

    localparam logic [1:0] FC_VERSION = 2'd1;
    localparam logic [1:0] FC_MODE    = 2'd2;
    localparam logic [1:0] FC_PROGRAM = 2'd3;

    typedef enum logic [2:0] {
        ACT_FLASH_DATA = 3'd0,
        ACT_VALUE_DATA = 3'd1,
        ACT_ACK        = 3'd2,
        ACT_ERROR      = 3'd3,
        ACT_START      = 3'd4,
        ACT_WRITE      = 3'd5,
        ACT_REBOOT     = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ERR_UNKNOWN_ID = 3'd0,
        ERR_NOT_FOUND  = 3'd1,
        ERR_ACCESS     = 3'd2,
        ERR_ILLEGAL_OP = 3'd3,
        ERR_DISK_FULL  = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        WM_NONE   = 2'd0,
        WM_MODE   = 2'd1,
        WM_PROG   = 2'd2,
        WM_REBOOT = 2'd3
    } t_wmode;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_SHORT = 3'd1,
        K_RRQ   = 3'd2,
        K_WRQ   = 3'd3,
        K_DATA  = 3'd4,
        K_ACK   = 3'd5,
        K_POLL  = 3'd6,
        K_TICK  = 3'd7
    } t_kind;

    typedef struct packed {
        logic [11:0] chunk;
        logic [15:0] version;
        logic [7:0]  mode;
        logic [9:0]  ackto;
        logic [7:0]  rbdelay;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] blk;
        logic [1:0]  fclass;
        logic [11:0] plen;
        logic        fb_zero;
        logic [15:0] okc;
        logic        failed;
        logic [11:0] rlen;
        logic        tx;
    } t_cmd;

    typedef struct packed {
        t_action     action;
        logic [15:0] blk;
        t_err        err;
        logic [11:0] count;
        logic [15:0] value;
    } t_res;

    typedef struct packed {
        t_action     action;
        logic [15:0] blk;
        t_err        err;
        logic [11:0] count;
        logic [26:0] addr;
        logic [15:0] value;
        logic        last;
    } t_out;

endpackage

[rtl/tbts_front.sv]
// Front end: classifies accepted items into queue commands and drops inert ones.
// Depends on tbts_pkg.
module tbts_front (
    input  logic [1:0]    i_opcode,
    input  logic          i_too_short,
    input  logic [15:0]   i_packet_type,
    input  logic [15:0]   i_block_in,
    input  logic [1:0]    i_file_class,
    input  logic [11:0]   i_payload_len,
    input  logic [7:0]    i_first_byte,
    input  logic [15:0]   i_flash_ok_count,
    input  logic          i_flash_failed,
    input  logic [11:0]   i_read_len,
    input  logic          i_tx_free,
    input  tbts_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    output tbts_pkg::t_cmd o_cmd,
    output logic          o_push
);
    import tbts_pkg::*;

    t_kind kind;

    always_comb begin
        kind = K_NONE;
        case (i_opcode)
            OP_PACKET: begin
                if (i_too_short) begin
                    kind = K_SHORT;
                end else if (i_packet_type == PT_RRQ) begin
                    kind = K_RRQ;
                end else if (i_packet_type == PT_WRQ) begin
                    kind = K_WRQ;
                end else if (i_packet_type == PT_DATA) begin
                    kind = K_DATA;
                end else if (i_packet_type == PT_ACK) begin
                    kind = K_ACK;
                end
            end
            OP_POLL: kind = K_POLL;
            OP_TICK: kind = K_TICK;
            default: kind = K_NONE;
        endcase
    end

    always_comb begin
        o_cmd.kind    = kind;
        o_cmd.blk     = i_block_in;
        o_cmd.fclass  = i_file_class;
        o_cmd.plen    = i_payload_len;
        o_cmd.fb_zero = (i_first_byte == 8'd0);
        o_cmd.okc     = i_flash_ok_count;
        o_cmd.failed  = i_flash_failed;
        o_cmd.rlen    = (i_read_len > i_cfg.chunk) ? i_cfg.chunk : i_read_len;
        o_cmd.tx      = i_tx_free;
    end

    assign o_push = i_accept && (kind != K_NONE);

endmodule

[rtl/tbts_queue.sv]
// Command queue between the front end and the back end.
// Depends on tbts_pkg.
module tbts_queue #(
    parameter int DEPTH = tbts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tbts_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output tbts_pkg::t_cmd o_cmd,
    output logic           o_valid,
    output logic           o_full
);
    import tbts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_cmd   = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");
`endif

endmodule

[rtl/tbts_back.sv]
// Back end: executes queued commands on the transfer state, buffers results
// and drains them through the output register. Depends on tbts_pkg.
module tbts_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tbts_pkg::t_cfg i_cfg,
    input  tbts_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_pop,
    output tbts_pkg::t_out o_out,
    output logic           o_out_valid,
    input  logic           i_out_ready
);
    import tbts_pkg::*;

    logic        r_read_active;
    logic [15:0] r_read_next, r_read_sent;
    t_wmode      r_wmode;
    logic [15:0] r_wpend, r_wacked, r_wexp;
    logic [9:0]  r_ack_timer;
    logic [7:0]  r_rb_timer;

    logic        n_read_active;
    logic [15:0] n_read_next, n_read_sent;
    t_wmode      n_wmode;
    logic [15:0] n_wpend, n_wacked, n_wexp;
    logic [9:0]  n_ack_timer;
    logic [7:0]  n_rb_timer;

    t_res        r_res [RES_SLOTS];
    logic [1:0]  r_total, r_idx;
    t_res        e_res [RES_SLOTS];
    logic [1:0]  e_n;

    t_out        r_out;
    logic        r_out_valid;
    logic        busy, out_free, load;
    t_res        ld;
    logic [15:0] ld_blk_m1;
    logic [27:0] ld_prod;

    function automatic t_res mk_res(t_action a, logic [15:0] b, t_err e,
                                    logic [11:0] c, logic [15:0] v);
        t_res r;
        r.action = a;
        r.blk    = b;
        r.err    = e;
        r.count  = c;
        r.value  = v;
        return r;
    endfunction

    assign busy     = (r_idx != r_total);
    assign o_pop    = i_cmd_valid && !busy;
    assign out_free = !r_out_valid || i_out_ready;
    assign load     = busy && out_free;

    always_comb begin
        logic [15:0] nx;
        logic        go;
        nx            = r_wexp + 16'd1;
        go            = 1'b0;
        n_read_active = r_read_active;
        n_read_next   = r_read_next;
        n_read_sent   = r_read_sent;
        n_wmode       = r_wmode;
        n_wpend       = r_wpend;
        n_wacked      = r_wacked;
        n_wexp        = r_wexp;
        n_ack_timer   = r_ack_timer;
        n_rb_timer    = r_rb_timer;
        e_n           = 2'd0;
        for (int k = 0; k < RES_SLOTS; k++) begin
            e_res[k] = '0;
        end
        case (i_cmd.kind)
            K_SHORT: begin
                if (i_cmd.tx) begin
                    e_res[e_n] = mk_res(ACT_ERROR, 16'd0, ERR_UNKNOWN_ID, 12'd0, 16'd0);
                    e_n = e_n + 2'd1;
                end
            end
            K_RRQ: begin
                if (i_cmd.fclass == FC_VERSION) begin
                    if (i_cmd.tx) begin
                        e_res[e_n] = mk_res(ACT_VALUE_DATA, 16'd1, ERR_UNKNOWN_ID, 12'd2,
                                            i_cfg.version);
                        e_n = e_n + 2'd1;
                    end
                end else if (i_cmd.fclass == FC_MODE) begin
                    if (i_cmd.tx) begin
                        e_res[e_n] = mk_res(ACT_VALUE_DATA, 16'd1, ERR_UNKNOWN_ID, 12'd1,
                                            {8'd0, i_cfg.mode});
                        e_n = e_n + 2'd1;
                    end
                end else if (i_cmd.fclass == FC_PROGRAM) begin
                    n_read_active = 1'b1;
                    n_read_next   = 16'd1;
                    n_read_sent   = 16'd0;
                end else begin
                    n_read_active = 1'b0;
                    if (i_cmd.tx) begin
                        e_res[e_n] = mk_res(ACT_ERROR, 16'd0, ERR_NOT_FOUND, 12'd0, 16'd0);
                        e_n = e_n + 2'd1;
                    end
                end
            end
            K_WRQ: begin
                if (i_cmd.fclass == FC_VERSION) begin
                    if (i_cmd.tx) begin
                        e_res[e_n] = mk_res(ACT_ERROR, 16'd0, ERR_ACCESS, 12'd0, 16'd0);
                        e_n = e_n + 2'd1;
                    end
                end else if (i_cmd.fclass == FC_MODE) begin
                    n_wmode = WM_MODE;
                    if (i_cmd.tx) begin
                        e_res[e_n] = mk_res(ACT_ACK, 16'd0, ERR_UNKNOWN_ID, 12'd0, 16'd0);
                        e_n = e_n + 2'd1;
                    end
                end else if (i_cmd.fclass == FC_PROGRAM) begin
                    n_wmode  = WM_PROG;
                    n_wpend  = 16'd0;
                    n_wacked = 16'd0;
                    n_wexp   = 16'd0;
                    if (i_cmd.tx) begin
                        e_res[e_n] = mk_res(ACT_ACK, 16'd0, ERR_UNKNOWN_ID, 12'd0, 16'd0);
                        e_n = e_n + 2'd1;
                    end
                    e_res[e_n] = mk_res(ACT_START, 16'd0, ERR_UNKNOWN_ID, 12'd0, 16'd0);
                    e_n = e_n + 2'd1;
                end else begin
                    n_wmode = WM_NONE;
                    if (i_cmd.tx) begin
                        e_res[e_n] = mk_res(ACT_ERROR, 16'd0, ERR_NOT_FOUND, 12'd0, 16'd0);
                        e_n = e_n + 2'd1;
                    end
                end
            end
            K_DATA: begin
                if (r_wmode == WM_PROG) begin
                    if (i_cmd.blk == nx) begin
                        n_wpend     = nx;
                        n_wexp      = nx;
                        n_ack_timer = 10'd0;
                        e_res[e_n] = mk_res(ACT_WRITE, nx, ERR_UNKNOWN_ID, i_cmd.plen, 16'd0);
                        e_n = e_n + 2'd1;
                    end
                end else if (r_wmode == WM_MODE) begin
                    if (i_cmd.blk == 16'd1 && i_cmd.fb_zero) begin
                        n_wmode    = WM_REBOOT;
                        n_rb_timer = 8'd0;
                        if (i_cmd.tx) begin
                            e_res[e_n] = mk_res(ACT_ACK, 16'd1, ERR_UNKNOWN_ID, 12'd0, 16'd0);
                            e_n = e_n + 2'd1;
                        end
                    end
                end else begin
                    n_wpend  = 16'd0;
                    n_wacked = 16'd0;
                    if (i_cmd.tx) begin
                        e_res[e_n] = mk_res(ACT_ERROR, 16'd0, ERR_ILLEGAL_OP, 12'd0, 16'd0);
                        e_n = e_n + 2'd1;
                    end
                end
            end
            K_ACK: begin
                if (i_cmd.blk == r_read_sent && r_read_next != 16'd0) begin
                    n_read_next = r_read_next + 16'd1;
                end else begin
                    n_read_next = 16'd0;
                    n_read_sent = 16'd0;
                end
            end
            K_POLL: begin
                if (r_read_next > r_read_sent) begin
                    if (r_read_active) begin
                        if (i_cmd.tx) begin
                            e_res[e_n] = mk_res(ACT_FLASH_DATA, r_read_next, ERR_UNKNOWN_ID,
                                                i_cmd.rlen, 16'd0);
                            e_n = e_n + 2'd1;
                            n_read_sent = r_read_next;
                            if (i_cmd.rlen < i_cfg.chunk) begin
                                n_read_next = 16'd0;
                            end
                        end
                    end else begin
                        n_read_next = 16'd0;
                        if (i_cmd.tx) begin
                            e_res[e_n] = mk_res(ACT_ERROR, 16'd0, ERR_ILLEGAL_OP, 12'd0, 16'd0);
                            e_n = e_n + 2'd1;
                        end
                    end
                end
                if (r_wpend > r_wacked) begin
                    if (r_wmode == WM_PROG) begin
                        go = (i_cmd.okc > r_wacked);
                        if (!go && r_ack_timer >= i_cfg.ackto) begin
                            go          = 1'b1;
                            n_ack_timer = 10'd0;
                        end
                        if (go) begin
                            n_wacked = r_wacked + 16'd1;
                            if (i_cmd.tx) begin
                                e_res[e_n] = mk_res(ACT_ACK, r_wacked + 16'd1, ERR_UNKNOWN_ID,
                                                    12'd0, 16'd0);
                                e_n = e_n + 2'd1;
                            end
                        end else if (i_cmd.failed) begin
                            n_wpend = 16'd0;
                            if (i_cmd.tx) begin
                                e_res[e_n] = mk_res(ACT_ERROR, 16'd0, ERR_DISK_FULL, 12'd0,
                                                    16'd0);
                                e_n = e_n + 2'd1;
                            end
                        end
                    end else begin
                        n_wpend = 16'd0;
                        if (i_cmd.tx) begin
                            e_res[e_n] = mk_res(ACT_ERROR, 16'd0, ERR_ILLEGAL_OP, 12'd0, 16'd0);
                            e_n = e_n + 2'd1;
                        end
                    end
                end
                if (r_wmode == WM_REBOOT && r_rb_timer >= i_cfg.rbdelay) begin
                    e_res[e_n] = mk_res(ACT_REBOOT, 16'd0, ERR_UNKNOWN_ID, 12'd0, 16'd0);
                    e_n = e_n + 2'd1;
                end
            end
            K_TICK: begin
                if (r_ack_timer != '1) begin
                    n_ack_timer = r_ack_timer + 10'd1;
                end
                if (r_rb_timer != '1) begin
                    n_rb_timer = r_rb_timer + 8'd1;
                end
            end
            default: begin
                n_wmode = r_wmode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_active <= 1'b0;
            r_read_next   <= '0;
            r_read_sent   <= '0;
            r_wmode       <= WM_NONE;
            r_wpend       <= '0;
            r_wacked      <= '0;
            r_wexp        <= '0;
            r_ack_timer   <= '0;
            r_rb_timer    <= '0;
        end else if (o_pop) begin
            r_read_active <= n_read_active;
            r_read_next   <= n_read_next;
            r_read_sent   <= n_read_sent;
            r_wmode       <= n_wmode;
            r_wpend       <= n_wpend;
            r_wacked      <= n_wacked;
            r_wexp        <= n_wexp;
            r_ack_timer   <= n_ack_timer;
            r_rb_timer    <= n_rb_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= e_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_idx   <= '0;
        end else if (o_pop) begin
            r_total <= e_n;
            r_idx   <= '0;
        end else if (load) begin
            if (r_idx + 2'd1 == r_total) begin
                r_total <= '0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign ld        = r_res[r_idx];
    assign ld_blk_m1 = ld.blk - 16'd1;
    assign ld_prod   = ld_blk_m1 * i_cfg.chunk;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.action <= ld.action;
            r_out.blk    <= ld.blk;
            r_out.err    <= ld.err;
            r_out.count  <= ld.count;
            r_out.value  <= ld.value;
            r_out.last   <= (r_idx + 2'd1 == r_total);
            r_out.addr   <= (ld.action == ACT_FLASH_DATA || ld.action == ACT_WRITE)
                            ? ld_prod[26:0] : 27'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= load;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !r_out.last) |=> r_out_valid)
        else $error("result burst broken before its last transfer");

    a_addr_only_flash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action != ACT_FLASH_DATA && r_out.action != ACT_WRITE)
        |-> (r_out.addr == 27'd0))
        else $error("flash address on a non-flash result");
`endif

endmodule

[rtl/tftp_boot_transfer_sequencer_top.sv]
// TFTP boot transfer sequencer: config registers, front end, command queue, back end.
// Results pass through the queue, the back end's result buffer and the output register. The back
// end executes one item, then loads its results into the output register one at a time, and
// pops the next item only once all of them are loaded; inert items leave no queue entry.
// Reset is synchronous, active low: it clears queue, transfer state, output valid and loads
// the configuration reset values. Depends on tbts_pkg and the tbts_* modules.
module tftp_boot_transfer_sequencer_top #(
    parameter int QUEUE_DEPTH = tbts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic        i_too_short,
    input  logic [15:0] i_packet_type,
    input  logic [15:0] i_block_in,
    input  logic [1:0]  i_file_class,
    input  logic [11:0] i_payload_len,
    input  logic [7:0]  i_first_byte,
    input  logic [15:0] i_flash_ok_count,
    input  logic        i_flash_failed,
    input  logic [11:0] i_read_len,
    input  logic        i_tx_free,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_action,
    output logic [15:0] o_block_out,
    output logic [2:0]  o_error_code,
    output logic [11:0] o_byte_count,
    output logic [26:0] o_flash_address,
    output logic [15:0] o_value_out,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tbts_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, queue_cmd;
    t_out back_out;
    logic front_push, queue_valid, queue_full, back_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chunk   <= CHUNK_RST;
            r_cfg.version <= VER_RST;
            r_cfg.mode    <= MODE_RST;
            r_cfg.ackto   <= ACKTO_RST;
            r_cfg.rbdelay <= RBDELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CHUNK:   r_cfg.chunk   <= i_cfg_data[11:0];
                CFG_VERSION: r_cfg.version <= i_cfg_data;
                CFG_MODE:    r_cfg.mode    <= i_cfg_data[7:0];
                CFG_ACKTO:   r_cfg.ackto   <= i_cfg_data[9:0];
                CFG_RBDELAY: r_cfg.rbdelay <= i_cfg_data[7:0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    assign o_in_ready = !queue_full;

    tbts_front u_front (
        .i_opcode         (i_opcode),
        .i_too_short      (i_too_short),
        .i_packet_type    (i_packet_type),
        .i_block_in       (i_block_in),
        .i_file_class     (i_file_class),
        .i_payload_len    (i_payload_len),
        .i_first_byte     (i_first_byte),
        .i_flash_ok_count (i_flash_ok_count),
        .i_flash_failed   (i_flash_failed),
        .i_read_len       (i_read_len),
        .i_tx_free        (i_tx_free),
        .i_cfg            (r_cfg),
        .i_accept         (i_in_valid && o_in_ready),
        .o_cmd            (front_cmd),
        .o_push           (front_push)
    );

    tbts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd),
        .o_valid (queue_valid),
        .o_full  (queue_full)
    );

    tbts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_pop       (back_pop),
        .o_out       (back_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    assign o_action        = back_out.action;
    assign o_block_out     = back_out.blk;
    assign o_error_code    = back_out.err;
    assign o_byte_count    = back_out.count;
    assign o_flash_address = back_out.addr;
    assign o_value_out     = back_out.value;
    assign o_last          = back_out.last;

endmodule

[tb/sv/boot_sequence_board.sv]
`timescale 1ns / 1ps
// Item type and scoreboard for the TFTP boot transfer sequencer testbench.
// The board predicts the actions each accepted item causes and checks the block's transfers.
// Depends on tbts_pkg.
package boot_board_pkg;
    import tbts_pkg::*;

    localparam logic [1:0]  OP_SPARE   = 2'd3;
    localparam logic [15:0] PT_ERROR   = 16'd5;
    localparam logic [1:0]  FC_UNKNOWN = 2'd0;
    // non-error actions carry code zero
    localparam t_err        ERR_NONE   = ERR_UNKNOWN_ID;

    typedef struct {
        logic [1:0]  opcode;
        logic        too_short;
        logic [15:0] ptype;
        logic [15:0] blk;
        logic [1:0]  fclass;
        logic [11:0] plen;
        logic [7:0]  fbyte;
        logic [15:0] okc;
        logic        failed;
        logic [11:0] rlen;
        logic        tx;
    } t_boot_item;

    class boot_sequence_board;
        logic [11:0] chunk;
        logic [15:0] version;
        logic [7:0]  mode_byte;
        logic [9:0]  ack_limit;
        logic [7:0]  reboot_delay;

        logic        read_active;
        logic [15:0] read_next_block;
        logic [15:0] read_sent_block;
        t_wmode      write_mode;
        logic [15:0] write_pending_block;
        logic [15:0] write_acked_block;
        logic [15:0] write_expected_block;
        logic [9:0]  ack_timer;
        logic [7:0]  reboot_timer;

        t_out awaited_actions[$];
        t_out fresh_actions[$];
        int   mismatches;

        function new();
            chunk                = CHUNK_RST;
            version              = VER_RST;
            mode_byte            = MODE_RST;
            ack_limit            = ACKTO_RST;
            reboot_delay         = RBDELAY_RST;
            read_active          = 1'b0;
            read_next_block      = 16'd0;
            read_sent_block      = 16'd0;
            write_mode           = WM_NONE;
            write_pending_block  = 16'd0;
            write_acked_block    = 16'd0;
            write_expected_block = 16'd0;
            ack_timer            = 10'd0;
            reboot_timer         = 8'd0;
            mismatches           = 0;
        endfunction

        function void set_register(logic [2:0] index, logic [15:0] data);
            case (index)
                CFG_CHUNK:   chunk        = data[11:0];
                CFG_VERSION: version      = data;
                CFG_MODE:    mode_byte    = data[7:0];
                CFG_ACKTO:   ack_limit    = data[9:0];
                CFG_RBDELAY: reboot_delay = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [26:0] flash_address(logic [15:0] blk);
            logic [15:0] index;
            logic [27:0] product;
            index   = blk - 16'd1;
            product = 28'(index) * 28'(chunk);
            return product[26:0];
        endfunction

        function void put(t_action act, logic [15:0] blk, t_err err, logic [11:0] count,
                          logic [26:0] addr, logic [15:0] value);
            t_out r;
            r.action = act;
            r.blk    = blk;
            r.err    = err;
            r.count  = count;
            r.addr   = addr;
            r.value  = value;
            r.last   = 1'b0;
            fresh_actions.push_back(r);
        endfunction

        function void on_packet(t_boot_item it);
            logic [15:0] nx;
            if (it.too_short) begin
                if (it.tx) put(ACT_ERROR, 16'd0, ERR_UNKNOWN_ID, 12'd0, 27'd0, 16'd0);
                return;
            end
            case (it.ptype)
                PT_RRQ: begin
                    case (it.fclass)
                        FC_VERSION: if (it.tx)
                            put(ACT_VALUE_DATA, 16'd1, ERR_NONE, 12'd2, 27'd0, version);
                        FC_MODE: if (it.tx)
                            put(ACT_VALUE_DATA, 16'd1, ERR_NONE, 12'd1, 27'd0, {8'd0, mode_byte});
                        FC_PROGRAM: begin
                            read_active     = 1'b1;
                            read_next_block = 16'd1;
                            read_sent_block = 16'd0;
                        end
                        default: begin
                            read_active = 1'b0;
                            if (it.tx) put(ACT_ERROR, 16'd0, ERR_NOT_FOUND, 12'd0, 27'd0, 16'd0);
                        end
                    endcase
                end
                PT_WRQ: begin
                    case (it.fclass)
                        FC_VERSION: if (it.tx)
                            put(ACT_ERROR, 16'd0, ERR_ACCESS, 12'd0, 27'd0, 16'd0);
                        FC_MODE: begin
                            write_mode = WM_MODE;
                            if (it.tx) put(ACT_ACK, 16'd0, ERR_NONE, 12'd0, 27'd0, 16'd0);
                        end
                        FC_PROGRAM: begin
                            write_mode           = WM_PROG;
                            write_pending_block  = 16'd0;
                            write_acked_block    = 16'd0;
                            write_expected_block = 16'd0;
                            if (it.tx) put(ACT_ACK, 16'd0, ERR_NONE, 12'd0, 27'd0, 16'd0);
                            put(ACT_START, 16'd0, ERR_NONE, 12'd0, 27'd0, 16'd0);
                        end
                        default: begin
                            write_mode = WM_NONE;
                            if (it.tx) put(ACT_ERROR, 16'd0, ERR_NOT_FOUND, 12'd0, 27'd0, 16'd0);
                        end
                    endcase
                end
                PT_DATA: begin
                    if (write_mode == WM_PROG) begin
                        nx = write_expected_block + 16'd1;
                        if (it.blk == nx) begin
                            write_pending_block  = nx;
                            write_expected_block = nx;
                            put(ACT_WRITE, nx, ERR_NONE, it.plen, flash_address(nx), 16'd0);
                            ack_timer = 10'd0;
                        end
                    end else if (write_mode == WM_MODE) begin
                        if (it.blk == 16'd1 && it.fbyte == 8'd0) begin
                            if (it.tx) put(ACT_ACK, 16'd1, ERR_NONE, 12'd0, 27'd0, 16'd0);
                            write_mode   = WM_REBOOT;
                            reboot_timer = 8'd0;
                        end
                    end else begin
                        write_pending_block = 16'd0;
                        write_acked_block   = 16'd0;
                        if (it.tx) put(ACT_ERROR, 16'd0, ERR_ILLEGAL_OP, 12'd0, 27'd0, 16'd0);
                    end
                end
                PT_ACK: begin
                    if (it.blk == read_sent_block && read_next_block != 16'd0) begin
                        read_next_block = read_next_block + 16'd1;
                    end else begin
                        read_next_block = 16'd0;
                        read_sent_block = 16'd0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void on_poll(t_boot_item it);
            logic [11:0] len;
            logic        go;
            if (read_next_block > read_sent_block) begin
                if (read_active) begin
                    if (it.tx) begin
                        len = (it.rlen > chunk) ? chunk : it.rlen;
                        put(ACT_FLASH_DATA, read_next_block, ERR_NONE, len,
                            flash_address(read_next_block), 16'd0);
                        read_sent_block = read_next_block;
                        if (len < chunk) read_next_block = 16'd0;
                    end
                end else begin
                    if (it.tx) put(ACT_ERROR, 16'd0, ERR_ILLEGAL_OP, 12'd0, 27'd0, 16'd0);
                    read_next_block = 16'd0;
                end
            end
            if (write_pending_block > write_acked_block) begin
                if (write_mode == WM_PROG) begin
                    go = (it.okc > write_acked_block);
                    if (!go && ack_timer >= ack_limit) begin
                        go        = 1'b1;
                        ack_timer = 10'd0;
                    end
                    if (go) begin
                        write_acked_block = write_acked_block + 16'd1;
                        if (it.tx)
                            put(ACT_ACK, write_acked_block, ERR_NONE, 12'd0, 27'd0, 16'd0);
                    end else if (it.failed) begin
                        if (it.tx) put(ACT_ERROR, 16'd0, ERR_DISK_FULL, 12'd0, 27'd0, 16'd0);
                        write_pending_block = 16'd0;
                    end
                end else begin
                    if (it.tx) put(ACT_ERROR, 16'd0, ERR_ILLEGAL_OP, 12'd0, 27'd0, 16'd0);
                    write_pending_block = 16'd0;
                end
            end
            if (write_mode == WM_REBOOT && reboot_timer >= reboot_delay)
                put(ACT_REBOOT, 16'd0, ERR_NONE, 12'd0, 27'd0, 16'd0);
        endfunction

        function void note_item(t_boot_item it);
            fresh_actions.delete();
            case (it.opcode)
                OP_PACKET: on_packet(it);
                OP_POLL:   on_poll(it);
                OP_TICK: begin
                    if (ack_timer != 10'h3FF) ack_timer = ack_timer + 10'd1;
                    if (reboot_timer != 8'hFF) reboot_timer = reboot_timer + 8'd1;
                end
                default: ;
            endcase
            if (fresh_actions.size() > 0) fresh_actions[fresh_actions.size() - 1].last = 1'b1;
            foreach (fresh_actions[k]) awaited_actions.push_back(fresh_actions[k]);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40) $display("[sb] mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_action(t_out got);
            t_out want;
            if (awaited_actions.size() == 0) begin
                report_mismatch($sformatf("unexpected action %0d block %0h",
                                          32'(got.action), got.blk));
                return;
            end
            want = awaited_actions.pop_front();
            compare_field("action", 32'(got.action), 32'(want.action));
            compare_field("block", 32'(got.blk), 32'(want.blk));
            compare_field("error_code", 32'(got.err), 32'(want.err));
            compare_field("byte_count", 32'(got.count), 32'(want.count));
            compare_field("flash_address", 32'(got.addr), 32'(want.addr));
            compare_field("value", 32'(got.value), 32'(want.value));
            compare_field("last", 32'(got.last), 32'(want.last));
        endtask
    endclass
endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top-level testbench for tftp_boot_transfer_sequencer_top: directed and random traffic,
// random idling on both channels, register phases and a watchdog.
// Depends on tbts_pkg and boot_board_pkg.
module testbench;
    import tbts_pkg::*;
    import boot_board_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_opcode;
    logic        i_too_short;
    logic [15:0] i_packet_type;
    logic [15:0] i_block_in;
    logic [1:0]  i_file_class;
    logic [11:0] i_payload_len;
    logic [7:0]  i_first_byte;
    logic [15:0] i_flash_ok_count;
    logic        i_flash_failed;
    logic [11:0] i_read_len;
    logic        i_tx_free;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_action;
    logic [15:0] o_block_out;
    logic [2:0]  o_error_code;
    logic [11:0] o_byte_count;
    logic [26:0] o_flash_address;
    logic [15:0] o_value_out;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    boot_sequence_board board;
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   quiet_cycles = 0;

    tftp_boot_transfer_sequencer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_too_short(i_too_short), .i_packet_type(i_packet_type),
        .i_block_in(i_block_in), .i_file_class(i_file_class), .i_payload_len(i_payload_len),
        .i_first_byte(i_first_byte), .i_flash_ok_count(i_flash_ok_count),
        .i_flash_failed(i_flash_failed), .i_read_len(i_read_len), .i_tx_free(i_tx_free),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_action(o_action), .o_block_out(o_block_out), .o_error_code(o_error_code),
        .o_byte_count(o_byte_count), .o_flash_address(o_flash_address),
        .o_value_out(o_value_out), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.action = t_action'(o_action);
            got.blk    = o_block_out;
            got.err    = t_err'(o_error_code);
            got.count  = o_byte_count;
            got.addr   = o_flash_address;
            got.value  = o_value_out;
            got.last   = o_last;
            board.check_action(got);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_boot_item noise_item();
        t_boot_item it;
        it.opcode    = 2'($urandom_range(0, 3));
        it.too_short = 1'($urandom_range(0, 1));
        it.ptype     = 16'($urandom);
        it.blk       = 16'($urandom);
        it.fclass    = 2'($urandom_range(0, 3));
        it.plen      = 12'($urandom_range(0, 2048));
        it.fbyte     = 8'($urandom);
        it.okc       = 16'($urandom);
        it.failed    = 1'($urandom_range(0, 1));
        it.rlen      = 12'($urandom_range(0, 2048));
        it.tx        = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_boot_item mk_packet(logic [15:0] ptype, logic [15:0] blk,
                                             logic [1:0] fclass, logic tx);
        t_boot_item it;
        it           = noise_item();
        it.opcode    = OP_PACKET;
        it.too_short = 1'b0;
        it.ptype     = ptype;
        it.blk       = blk;
        it.fclass    = fclass;
        it.tx        = tx;
        return it;
    endfunction

    function automatic t_boot_item mk_poll(logic [15:0] okc, logic failed, logic [11:0] rlen,
                                           logic tx);
        t_boot_item it;
        it        = noise_item();
        it.opcode = OP_POLL;
        it.okc    = okc;
        it.failed = failed;
        it.rlen   = rlen;
        it.tx     = tx;
        return it;
    endfunction

    function automatic t_boot_item mk_tick();
        t_boot_item it;
        it        = noise_item();
        it.opcode = OP_TICK;
        return it;
    endfunction

    // Bias toward sequences that follow the predicted transfer state.
    function automatic t_boot_item make_item();
        t_boot_item it;
        int pick;
        int r;
        it   = noise_item();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            it.opcode = OP_POLL;
            it.tx     = ($urandom_range(0, 6) != 0);
            case ($urandom_range(0, 3))
                0: it.rlen = board.chunk;
                1: it.rlen = 12'($urandom_range(0, board.chunk));
                2: it.rlen = 12'($urandom_range(board.chunk, 2048));
                default: ;
            endcase
            case ($urandom_range(0, 2))
                0: it.okc = board.write_acked_block + 16'd1;
                1: it.okc = board.write_acked_block;
                default: ;
            endcase
            it.failed = ($urandom_range(0, 6) == 0);
        end else if (pick < 35) begin
            it.opcode = OP_TICK;
        end else if (pick < 95) begin
            it.opcode    = OP_PACKET;
            it.too_short = 1'b0;
            it.tx        = ($urandom_range(0, 7) != 0);
            if (pick < 45) begin
                it.ptype = PT_RRQ;
                if ($urandom_range(0, 9) < 6) it.fclass = FC_PROGRAM;
            end else if (pick < 55) begin
                it.ptype = PT_WRQ;
                r = $urandom_range(0, 9);
                if (r < 4) it.fclass = FC_PROGRAM;
                else if (r < 6) it.fclass = FC_MODE;
            end else if (pick < 73) begin
                it.ptype = PT_DATA;
                if (board.write_mode == WM_MODE && $urandom_range(0, 4) != 0) begin
                    it.blk = 16'd1;
                    if ($urandom_range(0, 1) == 0) it.fbyte = 8'd0;
                end else if ($urandom_range(0, 4) != 0) begin
                    it.blk = board.write_expected_block + 16'd1;
                end
                if ($urandom_range(0, 1) == 0) it.plen = board.chunk;
            end else if (pick < 85) begin
                it.ptype = PT_ACK;
                if ($urandom_range(0, 4) != 0) it.blk = board.read_sent_block;
            end else if (pick < 90) begin
                it.too_short = 1'b1;
            end else if (pick < 92) begin
                it.ptype = PT_ERROR;
            end
        end
        return it;
    endfunction

    task automatic send_item(t_boot_item it);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= it.opcode;
        i_too_short      <= it.too_short;
        i_packet_type    <= it.ptype;
        i_block_in       <= it.blk;
        i_file_class     <= it.fclass;
        i_payload_len    <= it.plen;
        i_first_byte     <= it.fbyte;
        i_flash_ok_count <= it.okc;
        i_flash_failed   <= it.failed;
        i_read_len       <= it.rlen;
        i_tx_free        <= it.tx;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] index, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(index, data);
        @(negedge i_clk);
    endtask

    // Hold input, drain every awaited action, then let the pipeline empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.awaited_actions.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic configure(int phase);
        logic [15:0] vals [5];
        case (phase)
            0: vals = '{16'd1, 16'hFFFF, 16'h00FF, 16'd1, 16'd1};
            1: vals = '{16'd2048, 16'd0, 16'd0, 16'd1023, 16'd255};
            2: vals = '{16'($urandom_range(2, 64)), 16'($urandom), 16'($urandom_range(0, 255)),
                        16'($urandom_range(1, 8)), 16'($urandom_range(1, 8))};
            default: vals = '{16'($urandom_range(1, 700)), 16'($urandom),
                              16'($urandom_range(0, 255)), 16'($urandom_range(2, 30)),
                              16'($urandom_range(2, 30))};
        endcase
        cfg_write(CFG_CHUNK, vals[0]);
        cfg_write(CFG_VERSION, vals[1]);
        cfg_write(CFG_MODE, vals[2]);
        cfg_write(CFG_ACKTO, vals[3]);
        cfg_write(CFG_RBDELAY, vals[4]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        t_boot_item it;
        send_item(mk_packet(PT_RRQ, 16'd0, FC_VERSION, 1'b1));
        send_item(mk_packet(PT_RRQ, 16'hFFFF, FC_MODE, 1'b0));
        send_item(mk_packet(PT_RRQ, 16'd0, FC_UNKNOWN, 1'b1));
        send_item(mk_packet(PT_WRQ, 16'd0, FC_VERSION, 1'b1));
        it = mk_packet(PT_RRQ, 16'd0, FC_VERSION, 1'b1);
        it.too_short = 1'b1;
        send_item(it);
        send_item(mk_packet(PT_DATA, 16'd1, FC_UNKNOWN, 1'b1));
        send_item(mk_packet(PT_RRQ, 16'd0, FC_PROGRAM, 1'b1));
        send_item(mk_poll(16'd0, 1'b0, 12'd2048, 1'b0));
        send_item(mk_poll(16'd0, 1'b0, 12'd2048, 1'b1));
        send_item(mk_packet(PT_ACK, 16'd1, FC_UNKNOWN, 1'b1));
        send_item(mk_poll(16'd0, 1'b0, 12'd100, 1'b1));
        send_item(mk_packet(PT_ACK, 16'hFFFF, FC_UNKNOWN, 1'b1));
        send_item(mk_packet(PT_RRQ, 16'd0, FC_PROGRAM, 1'b1));
        send_item(mk_packet(PT_RRQ, 16'd0, FC_UNKNOWN, 1'b1));
        send_item(mk_poll(16'hFFFF, 1'b1, 12'd0, 1'b1));
        send_item(mk_packet(PT_WRQ, 16'd0, FC_PROGRAM, 1'b0));
        it = mk_packet(PT_DATA, 16'd1, FC_UNKNOWN, 1'b1);
        it.plen  = 12'd2048;
        it.fbyte = 8'hFF;
        send_item(it);
        send_item(mk_packet(PT_DATA, 16'd3, FC_UNKNOWN, 1'b1));
        send_item(mk_poll(16'd0, 1'b1, 12'd0, 1'b1));
        it = mk_packet(PT_DATA, 16'd2, FC_UNKNOWN, 1'b1);
        it.plen = 12'd0;
        send_item(it);
        send_item(mk_packet(PT_WRQ, 16'd0, FC_MODE, 1'b1));
        send_item(mk_poll(16'd0, 1'b0, 12'd0, 1'b1));
        it = mk_packet(PT_DATA, 16'd1, FC_UNKNOWN, 1'b1);
        it.fbyte = 8'd0;
        send_item(it);
        send_item(mk_packet(PT_ERROR, 16'd0, FC_UNKNOWN, 1'b1));
        send_item(mk_packet(16'hFFFF, 16'd0, FC_UNKNOWN, 1'b1));
        it = noise_item();
        it.opcode = OP_SPARE;
        send_item(it);
        send_item(mk_tick());
    endtask

    // Run both timers past their limits, then fire the timeout ack and the reboot.
    task automatic expire_timers();
        t_boot_item it;
        send_item(mk_packet(PT_WRQ, 16'd0, FC_PROGRAM, 1'b1));
        send_item(mk_packet(PT_DATA, 16'd1, FC_UNKNOWN, 1'b1));
        repeat (10) send_item(mk_tick());
        send_item(mk_poll(16'd0, 1'b0, 12'd0, 1'b1));
        send_item(mk_packet(PT_WRQ, 16'd0, FC_MODE, 1'b1));
        it = mk_packet(PT_DATA, 16'd1, FC_UNKNOWN, 1'b1);
        it.fbyte = 8'd0;
        send_item(it);
        repeat (10) send_item(mk_tick());
        send_item(mk_poll(16'd0, 1'b0, 12'd0, 1'b1));
    endtask

    initial begin
        board            = new();
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_opcode         = OP_PACKET;
        i_too_short      = 1'b0;
        i_packet_type    = 16'd0;
        i_block_in       = 16'd0;
        i_file_class     = FC_UNKNOWN;
        i_payload_len    = 12'd0;
        i_first_byte     = 8'd0;
        i_flash_ok_count = 16'd0;
        i_flash_failed   = 1'b0;
        i_read_len       = 12'd0;
        i_tx_free        = 1'b0;
        i_out_ready      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_CHUNK;
        i_cfg_data       = 16'd0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            configure(phase);
            if (phase == 2) expire_timers();
            for (int n = 0; n < 80; n++) begin
                quiet = (phase == 3 && n >= 50);
                send_item(make_item());
            end
        end
        i_in_valid <= 1'b0;
        while (board.awaited_actions.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
